@@ rtl/ddm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants of the decimal digit mask
// Widths, register indexes, mode codes and the shift-add-3 step used by the
// binary to BCD pipeline.
// ----------------------------------------------------------------------------
package ddm_pkg;

	localparam int VAL_W = 64;
	localparam int NUM_DIG = 20;
	localparam int DAB_STAGES = 8;
	localparam int DAB_BITS = VAL_W / DAB_STAGES;
	localparam int HOR_STEPS = 4;
	localparam int HOR_STAGES = NUM_DIG / HOR_STEPS;
	localparam int CFG_W = 5;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_DIGIT = 2'd2;

	// Mask modes.
	localparam logic [1:0] MODE_KEEP_FIRST = 2'd0;
	localparam logic [1:0] MODE_KEEP_LAST  = 2'd1;
	localparam logic [1:0] MODE_MASK_FIRST = 2'd2;
	localparam logic [1:0] MODE_MASK_LAST  = 2'd3;

	typedef logic [NUM_DIG-1:0][3:0] bcd_t;

	// Per-item data that rides along with the digits.
	typedef struct packed {
		logic             neg;
		logic [VAL_W-1:0] value;
	} ddm_meta_t;

	// One shift-add-3 step: adjust every digit, then shift in one binary bit.
	function automatic bcd_t dabble_step(input bcd_t b, input logic bin_in);
		bcd_t                   a;
		logic [NUM_DIG*4-1:0]   f;
		a = b;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (a[i] >= 4'd5) a[i] = a[i] + 4'd3;
		end
		f = a;
		f = {f[NUM_DIG*4-2:0], bin_in};
		return bcd_t'(f);
	endfunction

endpackage

@@ rtl/decimal_digit_mask_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_mask_top: decimal digit masking of signed 64-bit values
// Replaces selected decimal digits of a value's magnitude, keeping the sign.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock while the output is not stalled.
// Eight stages convert the magnitude to BCD, one stage selects and
// replaces digits, five stages rebuild the binary magnitude four digits
// at a time, and the output register restores the sign. A stall on the
// output freezes the whole pipeline, so in_stall follows out_stall while a
// result waits. Configuration must be written while no beat is in flight.
// ----------------------------------------------------------------------------
module decimal_digit_mask_top import ddm_pkg::*; #(
	parameter int MAX_DIGITS = 19
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             write_enable,
	input  logic [1:0]       reg_index,
	input  logic [CFG_W-1:0] write_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic signed [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic signed [VAL_W-1:0] masked_value
);

	logic [1:0]       mode_q;
	logic [4:0]       count_q;
	logic [CFG_W-1:0] digit_q;

	logic             en;
	logic             vld_s15;
	logic [VAL_W-1:0] res_s15;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_KEEP_FIRST;
			count_q <= 5'd4;
			digit_q <= 5'd1;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_MODE:  mode_q  <= write_data[1:0];
				REG_COUNT: count_q <= write_data;
				REG_DIGIT: digit_q <= write_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless a result is held at the output.
	assign en       = !(vld_s15 && out_stall);
	assign in_stall = !en;

	// Magnitude and sign of the incoming beat.
	ddm_meta_t        in_meta;
	logic [VAL_W-1:0] in_mag;
	assign in_meta.neg   = value[VAL_W-1];
	assign in_meta.value = value;
	assign in_mag        = value[VAL_W-1] ? (~value + 1'b1) : value;

	logic      vld_b;
	ddm_meta_t meta_b;
	bcd_t      bcd_b;

	ddm_bin2bcd u_bin2bcd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_meta  (in_meta),
		.in_mag   (in_mag),
		.out_vld  (vld_b),
		.out_meta (meta_b),
		.out_bcd  (bcd_b)
	);

	// Digit selection: count digits, derive the replaced range, substitute.
	logic [4:0] nd;
	logic [4:0] n_lim;
	logic [4:0] m_min;
	logic [4:0] lo;
	logic [4:0] hi;
	logic       d_ok;
	logic       pass;
	bcd_t       new_bcd;

	always_comb begin
		nd = '0;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (bcd_b[i] != 4'd0) nd = 5'(i + 1);
		end
		n_lim = (count_q > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : count_q;
		m_min = (n_lim < nd) ? n_lim : nd;
		d_ok  = !digit_q[CFG_W-1] && (digit_q[3:0] <= 4'd9);
		pass  = !d_ok || ((mode_q == MODE_KEEP_FIRST) && (nd <= n_lim));
		unique case (mode_q)
			MODE_KEEP_FIRST: begin
				lo = 5'd0;
				hi = nd - n_lim;
			end
			MODE_KEEP_LAST: begin
				lo = n_lim;
				hi = nd;
			end
			MODE_MASK_FIRST: begin
				lo = nd - m_min;
				hi = nd;
			end
			default: begin
				lo = 5'd0;
				hi = m_min;
			end
		endcase
		for (int i = 0; i < NUM_DIG; i++) begin
			if ((5'(i) >= lo) && (5'(i) < hi)) new_bcd[i] = digit_q[3:0];
			else new_bcd[i] = bcd_b[i];
		end
	end

	logic      vld_s9;
	ddm_meta_t meta_s9;
	logic      pass_s9;
	bcd_t      bcd_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s9 <= meta_b;
			pass_s9 <= pass;
			bcd_s9  <= new_bcd;
		end
	end

	// Rebuild the magnitude from the top digit down, four digits per stage.
	logic             vld_h  [HOR_STAGES];
	ddm_meta_t        meta_h [HOR_STAGES];
	logic             pass_h [HOR_STAGES];
	bcd_t             bcd_h  [HOR_STAGES];
	logic [VAL_W-1:0] acc_h  [HOR_STAGES];

	genvar g;
	generate
		for (g = 0; g < HOR_STAGES; g++) begin : g_hor
			logic             src_vld;
			ddm_meta_t        src_meta;
			logic             src_pass;
			bcd_t             src_bcd;
			logic [VAL_W-1:0] src_acc;
			logic [VAL_W-1:0] nxt_acc;

			if (g == 0) begin : g_first
				assign src_vld  = vld_s9;
				assign src_meta = meta_s9;
				assign src_pass = pass_s9;
				assign src_bcd  = bcd_s9;
				assign src_acc  = '0;
			end else begin : g_next
				assign src_vld  = vld_h[g-1];
				assign src_meta = meta_h[g-1];
				assign src_pass = pass_h[g-1];
				assign src_bcd  = bcd_h[g-1];
				assign src_acc  = acc_h[g-1];
			end

			// Multiply by ten with two shifts and add the next digit.
			always_comb begin
				nxt_acc = src_acc;
				for (int k = 0; k < HOR_STEPS; k++) begin
					nxt_acc = {nxt_acc[VAL_W-4:0], 3'b000} + {nxt_acc[VAL_W-2:0], 1'b0}
						+ VAL_W'(src_bcd[NUM_DIG-1-g*HOR_STEPS-k]);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_h[g] <= 1'b0;
				end else if (en) begin
					vld_h[g] <= src_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					meta_h[g] <= src_meta;
					pass_h[g] <= src_pass;
					bcd_h[g]  <= src_bcd;
					acc_h[g]  <= nxt_acc;
				end
			end
		end
	endgenerate

	// Output register: restore the sign or pass the value through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
		end else if (en) begin
			vld_s15 <= vld_h[HOR_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pass_h[HOR_STAGES-1]) res_s15 <= meta_h[HOR_STAGES-1].value;
			else if (meta_h[HOR_STAGES-1].neg) res_s15 <= ~acc_h[HOR_STAGES-1] + 1'b1;
			else res_s15 <= acc_h[HOR_STAGES-1];
		end
	end

	assign out_valid    = vld_s15;
	assign masked_value = res_s15;

endmodule

@@ rtl/ddm_bin2bcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddm_bin2bcd: pipelined binary to BCD converter
// Converts a 64-bit magnitude to twenty BCD digits, eight bits per stage.
// ----------------------------------------------------------------------------
module ddm_bin2bcd import ddm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  ddm_meta_t        in_meta,
	input  logic [VAL_W-1:0] in_mag,
	output logic             out_vld,
	output ddm_meta_t        out_meta,
	output bcd_t             out_bcd
);

	logic             vld_s  [DAB_STAGES];
	ddm_meta_t        meta_s [DAB_STAGES];
	bcd_t             bcd_s  [DAB_STAGES];
	logic [VAL_W-1:0] bin_s  [DAB_STAGES];

	genvar g;
	generate
		for (g = 0; g < DAB_STAGES; g++) begin : g_stage
			logic             src_vld;
			ddm_meta_t        src_meta;
			bcd_t             src_bcd;
			logic [VAL_W-1:0] src_bin;
			bcd_t             nxt_bcd;

			// Pick the beat coming from the previous stage.
			if (g == 0) begin : g_first
				assign src_vld  = in_vld;
				assign src_meta = in_meta;
				assign src_bcd  = '0;
				assign src_bin  = in_mag;
			end else begin : g_next
				assign src_vld  = vld_s[g-1];
				assign src_meta = meta_s[g-1];
				assign src_bcd  = bcd_s[g-1];
				assign src_bin  = bin_s[g-1];
			end

			// Shift in the next eight binary bits, most significant first.
			always_comb begin
				nxt_bcd = src_bcd;
				for (int k = 0; k < DAB_BITS; k++) begin
					nxt_bcd = dabble_step(nxt_bcd, src_bin[VAL_W-1-k]);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en) begin
					vld_s[g] <= src_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					meta_s[g] <= src_meta;
					bcd_s[g]  <= nxt_bcd;
					bin_s[g]  <= src_bin << DAB_BITS;
				end
			end
		end
	endgenerate

	assign out_vld  = vld_s[DAB_STAGES-1];
	assign out_meta = meta_s[DAB_STAGES-1];
	assign out_bcd  = bcd_s[DAB_STAGES-1];

endmodule
